// File: hw/rtl/sba_pkg.sv
// shared widths, register indexes, reset values and state codes of the segment allocator
`timescale 1ns / 1ps

package sba_pkg;

   // payload widths
   localparam int REQ_SIZE_W   = 32;
   localparam int KEY_HASH_W   = 32;
   localparam int SEG_INDEX_W  = 4;
   localparam int OFFSET_W     = 32;
   localparam int FILL_W       = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   // configuration register widths
   localparam int SEG_LOG2_W   = 3;
   localparam int SEG_SIZE_W   = 32;
   localparam int SEG_MASK_W   = 16;

   // configuration reset values
   localparam logic [SEG_LOG2_W-1:0] SEG_LOG2_RESET = 3'd4;
   localparam logic [SEG_SIZE_W-1:0] SEG_SIZE_RESET = 32'd1048576;
   localparam logic [SEG_MASK_W-1:0] SEG_MASK_RESET = 16'hFFFF;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEG_COUNT_LOG2 = 2'd0,
      CSR_SEG_SIZE       = 2'd1,
      CSR_SEG_PRESENT    = 2'd2
   } csr_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PROBE = 2'b10
   } state_type;

endpackage

// File: hw/rtl/sba_req_if.sv
// request channel: allocation size and key hash
`timescale 1ns / 1ps

interface sba_req_if;
   import sba_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_SIZE_W-1:0] request_size;
   logic [KEY_HASH_W-1:0] key_hash;

   modport source (output valid, output request_size, output key_hash, input ready);
   modport sink   (input valid, input request_size, input key_hash, output ready);
endinterface

// File: hw/rtl/sba_rsp_if.sv
// response channel: placement of one allocation
`timescale 1ns / 1ps

interface sba_rsp_if;
   import sba_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SEG_INDEX_W-1:0] segment_index;
   logic [OFFSET_W-1:0]    byte_offset;
   logic                   recycled;
   logic                   alloc_error;

   modport source (output valid, output segment_index, output byte_offset,
                   output recycled, output alloc_error, input ready);
   modport sink   (input valid, input segment_index, input byte_offset,
                   input recycled, input alloc_error, output ready);
endinterface

// File: hw/rtl/sba_csr_if.sv
// configuration write channel: register index and write data
`timescale 1ns / 1ps

interface sba_csr_if;
   import sba_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: hw/rtl/segmented_bump_allocator.sv
// segmented bump-pointer allocator: probe sequencer around the segment fill memory
//
// Usage: each req_chan transaction carries a request size and a key hash. The
// hash's low bits choose a start segment; up to MAX_PROBES segments are probed
// in order, wrapping at the active segment count. The first present segment
// with enough free space is bumped; if none fits, the segment after the last
// probe is recycled (fill set to the request size, offset zero) or an error is flagged.
// One rsp_chan transaction comes back per request.
// Probing: the fill memory is read one segment per cycle; the first read issues
// at the accepting edge, and rsp valid rises once a probe is decided and the
// output register is free.
// Requests: one at a time; the next is taken the cycle after the previous one
// has been decided, limited by the single fill memory read port.
// csr_chan is always ready; write it only while no request is in flight.
// Reset: configuration returns to its defaults and per-segment valid bits clear,
// so every segment reads as empty at once, with no clearing pass.
// Stalls: the response sits in an output register; a new request is still
// accepted, and it waits for the slot only when its own result is ready.
`timescale 1ns / 1ps

module segmented_bump_allocator #(
   parameter int MAX_SEGMENTS = 16,
   parameter int MAX_PROBES   = 4
) (
   input  logic            clock,
   input  logic            reset,
   sba_req_if.sink         req_chan,
   sba_rsp_if.source       rsp_chan,
   sba_csr_if.sink         csr_chan
);
   import sba_pkg::*;

   localparam int SEG_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int LOG2_MAX = $clog2(MAX_SEGMENTS + 1) - 1;
   localparam int CNT_W    = SEG_W + 1;
   localparam int PRB_W    = $clog2(MAX_PROBES + 1);
   localparam int CMP_W    = (CNT_W > PRB_W) ? CNT_W : PRB_W;
   localparam int EFF_W    = 4;

   // configuration registers
   logic [SEG_LOG2_W-1:0] seg_log2_ff;
   logic [SEG_SIZE_W-1:0] seg_size_ff;
   logic [SEG_MASK_W-1:0] seg_mask_ff;

   // sequencer and request registers
   state_type             state_ff, state_in;
   logic [SEG_W-1:0]      cur_ff, cur_in;
   logic [PRB_W-1:0]      probe_ff, probe_in;
   logic [REQ_SIZE_W-1:0] req_size_ff, req_size_in;

   // fill memory, read data and per-entry valid bits
   logic [FILL_W-1:0]       fill_mem [MAX_SEGMENTS];
   logic [FILL_W-1:0]       fill_rd_ff;
   logic [MAX_SEGMENTS-1:0] fill_vld_ff;
   logic                    rd_en;
   logic [SEG_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [SEG_W-1:0]        wr_addr;
   logic [FILL_W-1:0]       wr_data;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEG_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [OFFSET_W-1:0]    rsp_offset_ff, rsp_offset_in;
   logic                   rsp_recycled_ff, rsp_recycled_in;
   logic                   rsp_error_ff, rsp_error_in;
   logic                   rsp_load;

   // derived probe controls
   logic [EFF_W-1:0] eff_log2;
   logic [SEG_W-1:0] seg_mask;
   logic [CNT_W-1:0] seg_count;
   logic             req_accept;
   logic             out_free;
   logic [FILL_W-1:0] cur_fill;
   logic             cur_fits;
   logic [SEG_W-1:0] cur_next;
   logic [PRB_W-1:0] probe_next;
   logic             probe_last;
   logic             fb_error;

   function automatic logic seg_present(input logic [SEG_W-1:0] s);
      seg_present = ((s >> SEG_INDEX_W) == '0) && seg_mask_ff[SEG_INDEX_W'(s)];
   endfunction

   // configuration writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_log2_ff <= SEG_LOG2_RESET;
         seg_size_ff <= SEG_SIZE_RESET;
         seg_mask_ff <= SEG_MASK_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_SEG_COUNT_LOG2: seg_log2_ff <= csr_chan.wr_data[SEG_LOG2_W-1:0];
            CSR_SEG_SIZE:       seg_size_ff <= csr_chan.wr_data[SEG_SIZE_W-1:0];
            CSR_SEG_PRESENT:    seg_mask_ff <= csr_chan.wr_data[SEG_MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // active segment count, clamped to the memory depth
   always_comb begin
      if (EFF_W'(seg_log2_ff) > EFF_W'(LOG2_MAX)) begin
         eff_log2 = EFF_W'(LOG2_MAX);
      end else begin
         eff_log2 = EFF_W'(seg_log2_ff);
      end
      for (int i = 0; i < SEG_W; i++) begin
         seg_mask[i] = (i < int'(eff_log2));
      end
      seg_count = CNT_W'(1) << eff_log2;
   end

   // probe evaluation on the registered fill word
   assign req_accept = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign cur_fill   = fill_vld_ff[cur_ff] ? fill_rd_ff : '0;
   assign cur_fits   = seg_present(cur_ff) && !(cur_fill > seg_size_ff) &&
                       ((seg_size_ff - cur_fill) >= req_size_ff);
   assign cur_next   = (cur_ff + SEG_W'(1)) & seg_mask;
   assign probe_next = probe_ff + PRB_W'(1);
   assign probe_last = (CMP_W'(probe_next) >= CMP_W'(seg_count)) ||
                       (CMP_W'(probe_next) >= CMP_W'(MAX_PROBES));
   assign fb_error   = !seg_present(cur_next) || (req_size_ff > seg_size_ff);

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      probe_in        = probe_ff;
      req_size_in     = req_size_ff;
      rd_en           = 1'b0;
      rd_addr         = cur_ff;
      wr_en           = 1'b0;
      wr_addr         = cur_ff;
      wr_data         = '0;
      rsp_load        = 1'b0;
      rsp_index_in    = rsp_index_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_recycled_in = rsp_recycled_ff;
      rsp_error_in    = rsp_error_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cur_in      = SEG_W'(req_chan.key_hash) & seg_mask;
               probe_in    = '0;
               req_size_in = req_chan.request_size;
               rd_en       = 1'b1;
               rd_addr     = SEG_W'(req_chan.key_hash) & seg_mask;
               state_in    = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (cur_fits) begin
               // bump the fill of the probed segment
               if (out_free) begin
                  wr_en           = 1'b1;
                  wr_addr         = cur_ff;
                  wr_data         = cur_fill + req_size_ff;
                  rsp_load        = 1'b1;
                  rsp_index_in    = SEG_INDEX_W'(cur_ff);
                  rsp_offset_in   = cur_fill;
                  rsp_recycled_in = 1'b0;
                  rsp_error_in    = 1'b0;
                  state_in        = ST_IDLE;
               end
            end else if (!probe_last) begin
               // read the next segment in probe order
               rd_en    = 1'b1;
               rd_addr  = cur_next;
               cur_in   = cur_next;
               probe_in = probe_next;
            end else if (out_free) begin
               // recycle the segment after the last probe
               wr_en           = !fb_error;
               wr_addr         = cur_next;
               wr_data         = req_size_ff;
               rsp_load        = 1'b1;
               rsp_index_in    = SEG_INDEX_W'(cur_next);
               rsp_offset_in   = '0;
               rsp_recycled_in = !fb_error;
               rsp_error_in    = fb_error;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff      <= cur_in;
      probe_ff    <= probe_in;
      req_size_ff <= req_size_in;
   end

   // fill memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fill_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         fill_rd_ff <= fill_mem[rd_addr];
      end
   end

   // valid bits: an entry never written reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (wr_en) begin
         fill_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // response output register
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff    <= rsp_index_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_recycled_ff <= rsp_recycled_in;
      rsp_error_ff    <= rsp_error_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.segment_index = rsp_index_ff;
   assign rsp_chan.byte_offset   = rsp_offset_ff;
   assign rsp_chan.recycled      = rsp_recycled_ff;
   assign rsp_chan.alloc_error   = rsp_error_ff;

   // memory is only written when a probe sequence ends
   a_write_in_probe: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_PROBE) && rsp_load)
      else $error("fill write outside a finishing probe");

   // read and write never share a cycle, so no forwarding is needed
   a_no_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("fill read and write in the same cycle");

   // probe counter stays below the probe limit
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (CMP_W'(probe_ff) < CMP_W'(MAX_PROBES)))
      else $error("probe counter beyond limit");

   // a result never overwrites one still waiting
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response register overwritten");

   // an accepted request always starts probing with a fresh read
   a_accept_probe: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_PROBE) && (probe_ff == '0))
      else $error("accepted request did not start probing");

endmodule

// File: bench/segmented_bump_allocator_tb.sv
// self-checking testbench for the segmented bump-pointer allocator
`timescale 1ns / 1ps

module segmented_bump_allocator_tb;
   import sba_pkg::*;

   localparam int MAX_SEGMENTS = 16;
   localparam int PROBE_LIMIT  = 4;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 95;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   // one placement as seen on the response channel
   typedef struct packed {
      logic [SEG_INDEX_W-1:0] segment_index;
      logic [OFFSET_W-1:0]    byte_offset;
      logic                   recycled;
      logic                   alloc_error;
   } placement_type;

   // mirror of the allocator: registers, segment fills and expected placements
   class allocation_tracker;
      logic [SEG_LOG2_W-1:0] count_log2;
      logic [SEG_SIZE_W-1:0] seg_size;
      logic [SEG_MASK_W-1:0] present_mask;
      logic [FILL_W-1:0]     fill [MAX_SEGMENTS];
      placement_type         placements [$];
      int unsigned           failures;

      function new();
         count_log2   = SEG_LOG2_RESET;
         seg_size     = SEG_SIZE_RESET;
         present_mask = SEG_MASK_RESET;
         foreach (fill[i]) fill[i] = '0;
         failures = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SEG_COUNT_LOG2: count_log2 = data[SEG_LOG2_W-1:0];
            CSR_SEG_SIZE:       seg_size = data[SEG_SIZE_W-1:0];
            CSR_SEG_PRESENT:    present_mask = data[SEG_MASK_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [REQ_SIZE_W-1:0] size, logic [KEY_HASH_W-1:0] hash);
         int unsigned   count;
         int unsigned   probes;
         int unsigned   cur;
         int unsigned   k;
         bit            placed;
         placement_type p;
         // active segment count, capped at the largest power of two that exists
         count = 1;
         k = 0;
         while (k < count_log2 && count * 2 <= MAX_SEGMENTS) begin
            count = count * 2;
            k++;
         end
         probes = (count < PROBE_LIMIT) ? count : PROBE_LIMIT;
         cur = hash & (count - 1);
         placed = 0;
         p = '0;
         // linear probe for the first present segment with enough room
         for (int t = 0; t < probes; t++) begin
            if (!placed) begin
               if (present_mask[cur] && fill[cur] <= seg_size && seg_size - fill[cur] >= size)
               begin
                  p.segment_index = cur[SEG_INDEX_W-1:0];
                  p.byte_offset = fill[cur];
                  fill[cur] = fill[cur] + size;
                  placed = 1;
               end else begin
                  cur = (cur + 1) & (count - 1);
               end
            end
         end
         // nothing fit: recycle the segment after the last probe, or flag an error
         if (!placed) begin
            p.segment_index = cur[SEG_INDEX_W-1:0];
            p.byte_offset = '0;
            if (!present_mask[cur] || size > seg_size) begin
               p.alloc_error = 1'b1;
            end else begin
               fill[cur] = size;
               p.recycled = 1'b1;
            end
         end
         placements.push_back(p);
      endfunction

      function void check_result(placement_type got);
         placement_type want;
         if (placements.size() == 0) begin
            $display("%0t: unexpected response: segment %0d offset %h recycled %b error %b",
                     $time, got.segment_index, got.byte_offset, got.recycled, got.alloc_error);
            failures++;
            return;
         end
         want = placements.pop_front();
         if (got.segment_index !== want.segment_index) begin
            $display("%0t: segment_index mismatch: expected %0d actual %0d",
                     $time, want.segment_index, got.segment_index);
            failures++;
         end
         if (got.byte_offset !== want.byte_offset) begin
            $display("%0t: byte_offset mismatch: expected %h actual %h",
                     $time, want.byte_offset, got.byte_offset);
            failures++;
         end
         if (got.recycled !== want.recycled) begin
            $display("%0t: recycled mismatch: expected %b actual %b",
                     $time, want.recycled, got.recycled);
            failures++;
         end
         if (got.alloc_error !== want.alloc_error) begin
            $display("%0t: alloc_error mismatch: expected %b actual %b",
                     $time, want.alloc_error, got.alloc_error);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;

   sba_req_if req_chan ();
   sba_rsp_if rsp_chan ();
   sba_csr_if csr_chan ();

   allocation_tracker tracker = new();

   segmented_bump_allocator #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .MAX_PROBES   (PROBE_LIMIT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // clock generator
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   // response sink with random stall bursts
   initial begin
      int unsigned   stall;
      placement_type got;
      rsp_chan.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.segment_index = rsp_chan.segment_index;
            got.byte_offset = rsp_chan.byte_offset;
            got.recycled = rsp_chan.recycled;
            got.alloc_error = rsp_chan.alloc_error;
            tracker.check_result(got);
         end
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 3) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // one request transaction, with an optional idle burst ahead of it
   task automatic send_request(logic [REQ_SIZE_W-1:0] size, logic [KEY_HASH_W-1:0] hash);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.request_size <= size;
      req_chan.key_hash <= hash;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_request(size, hash);
   endtask

   // stop requesting and wait until every placement has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (tracker.placements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one configuration transaction, valid left high for a following write
   task automatic csr_transfer(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wr_data <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   // program all registers, optionally with a write to the unmapped index
   task automatic configure(logic [CSR_DATA_W-1:0] log2_data, logic [CSR_DATA_W-1:0] size_data,
                            logic [CSR_DATA_W-1:0] mask_data, bit poke_unmapped);
      if (poke_unmapped) csr_transfer(CSR_UNMAPPED, $urandom());
      csr_transfer(CSR_SEG_COUNT_LOG2, log2_data);
      csr_transfer(CSR_SEG_SIZE, size_data);
      csr_transfer(CSR_SEG_PRESENT, mask_data);
      csr_chan.valid <= 1'b0;
   endtask

   // request sizes mostly scaled to the segment so segments fill and recycle
   function automatic logic [REQ_SIZE_W-1:0] pick_size(logic [SEG_SIZE_W-1:0] cap);
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return $urandom();
         3:       return cap;
         4:       return cap + 1;
         5:       return $urandom_range(0, cap);
         default: return $urandom_range(0, cap / 4);
      endcase
   endfunction

   // stimulus
   initial begin
      logic [CSR_DATA_W-1:0] size_data;
      logic [CSR_DATA_W-1:0] mask_data;
      quiet = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.request_size = '0;
      req_chan.key_hash = '0;
      csr_chan.valid = 1'b0;
      csr_chan.reg_index = CSR_SEG_COUNT_LOG2;
      csr_chan.wr_data = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: bump, skip a full segment, oversized, recycle
      send_request(32'd0, 32'd0);
      send_request(32'd1048576, 32'd1);
      send_request(32'd1, 32'd1);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int s = 4; s < 8; s++) send_request(32'd1048576, s);
      send_request(32'd16, 32'd4);

      // four segments, one absent, capacity below an existing fill
      settle();
      configure(32'd2, 32'd1000, 32'h0000_FFFB, 1'b1);
      send_request(32'd10, 32'd1);
      send_request(32'd1000, 32'd2);
      send_request(32'd5, 32'd1);
      send_request(32'd999, 32'd1);
      send_request(32'd1001, 32'd0);

      // single segment of maximum capacity
      settle();
      configure(32'd0, 32'hFFFF_FFFF, 32'd1, 1'b0);
      send_request(32'h8000_0000, 32'hFFFF_FFFF);
      send_request(32'h8000_0000, 32'hFFFF_FFFF);

      // oversized count, every segment absent
      settle();
      configure(32'hFFFF_FFFF, 32'd0, 32'hFFFF_0000, 1'b0);
      send_request(32'd0, 32'hA5A5_A5A5);

      // zero capacity segments
      settle();
      configure(32'd4, 32'd0, 32'h0000_FFFF, 1'b0);
      send_request(32'd0, 32'd3);
      send_request(32'd1, 32'd10);
      send_request(32'd0, 32'd10);

      // random phases, each under its own configuration
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         quiet = (phase == RANDOM_PHASES - 1);
         case ($urandom_range(0, 5))
            0:       size_data = $urandom_range(1, 64);
            1:       size_data = $urandom_range(64, 4096);
            2:       size_data = $urandom();
            3:       size_data = '1;
            4:       size_data = '0;
            default: size_data = SEG_SIZE_RESET;
         endcase
         case ($urandom_range(0, 4))
            0:       mask_data = '0;
            1:       mask_data = $urandom() & $urandom();
            2:       mask_data = $urandom();
            default: mask_data = {16'($urandom_range(0, 65535)), 16'hFFFF};
         endcase
         configure($urandom(), size_data, mask_data, $urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_request(pick_size(tracker.seg_size), $urandom());
         end
      end
      settle();

      if (tracker.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sba_pkg.sv
hw/rtl/sba_req_if.sv
hw/rtl/sba_rsp_if.sv
hw/rtl/sba_csr_if.sv
hw/rtl/segmented_bump_allocator.sv
bench/segmented_bump_allocator_tb.sv
